// ===== rtl/cbd_pkg.sv =====
// Shared types and constants for the binary metafile command deframer.
// Used by the front parser, the result queue, the output stage and the top level.
`timescale 1ns / 1ps
package cbd_pkg;

    // Default width of the saturating parameter length counter.
    localparam int DEF_LENGTH_BITS = 24;

    // Widths of the result fields.
    localparam int PARAM_LEN_W = 24;
    localparam int OFFSET_W    = 32;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // Result queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // One result item as it travels from the parser to the output.
    typedef struct packed {
        logic [7:0]             param_byte;
        logic                   param_valid;
        logic                   cmd_last;
        logic [3:0]             elem_class;
        logic [6:0]             element_id;
        logic [PARAM_LEN_W-1:0] param_length;
        logic [OFFSET_W-1:0]    cmd_offset;
        logic                   long_form;
    } t_result;

endpackage

// ===== rtl/cgm_binary_command_deframer_core.sv =====
// Top level of the binary metafile command deframer.
// Instantiates cbd_front, cbd_queue and cbd_back; depends on cbd_pkg.
//
// Usage:
//   Input channel: one metafile byte per beat on i_s_tdata; i_s_tuser is
//   the restart flag, which clears the parser and the byte offset before
//   that byte is parsed. Output channel: one beat per parameter byte and
//   one beat for each empty command and for each long-form command whose
//   final partition is empty; o_m_tlast marks the beat that completes a
//   command, and that beat carries the final parameter length and the
//   stream offset of the command header. Header, partition word and
//   short-form pad bytes give no other output beat. Each result beat is
//   written into the result queue and then into the output register
//   before the receiver can take it. Throughput: one byte per cycle while
//   the result queue has room; the four-entry result queue and the
//   output register let the input keep flowing while an output beat waits.
//   When the receiver stalls, the queue fills and o_s_tready falls once it
//   is full; no result is lost. Reset clears the parser, the offset
//   counter, the queue and the output register.
`timescale 1ns / 1ps
module cgm_binary_command_deframer_core
    import cbd_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] stream_byte
    input  logic                 i_s_tuser,   // [0] stream_restart
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] param_byte, [11:8] elem_class, [18:12] element_id,
    // [42:19] param_length, [74:43] cmd_offset, [79:75] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast,   // cmd_last
    output logic [M_TUSER_W-1:0] o_m_tuser    // [0] param_valid, [1] long_form
);

    logic    take;
    logic    push;
    logic    has_room;
    logic    not_empty;
    logic    pop;
    t_result front_result;
    t_result queue_result;

    assign o_s_tready = has_room;
    assign take       = i_s_tvalid & has_room;

    cbd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_byte    (i_s_tdata),
        .i_restart (i_s_tuser),
        .o_push    (push),
        .o_result  (front_result)
    );

    cbd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (front_result),
        .o_has_room  (has_room),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_data      (queue_result)
    );

    cbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (not_empty),
        .i_data     (queue_result),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== rtl/cbd_front.sv =====
// Front part of the deframer: accepts stream beats, tracks the command phase
// and produces result items. Depends on cbd_pkg.
`timescale 1ns / 1ps
module cbd_front
    import cbd_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,     // a beat is accepted this cycle
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    output logic       o_push,     // a result item is produced this cycle
    output t_result    o_result
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_SDATA = 3'd2;
    localparam logic [2:0] PH_SPAD  = 3'd3;
    localparam logic [2:0] PH_PART0 = 3'd4;
    localparam logic [2:0] PH_PART1 = 3'd5;
    localparam logic [2:0] PH_LDATA = 3'd6;

    localparam int EXT_W = (LENGTH_BITS > PARAM_LEN_W) ? LENGTH_BITS : PARAM_LEN_W;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [2:0]             r_phase, n_phase, b_phase;
    logic [7:0]             r_first, n_first, b_first;
    logic [3:0]             r_class, n_class, b_class;
    logic [6:0]             r_elem, n_elem, b_elem;
    logic [15:0]            r_remain, n_remain, b_remain;
    logic                   r_more, n_more, b_more;
    logic                   r_long, n_long, b_long;
    logic                   r_pad, n_pad, b_pad;
    logic [LENGTH_BITS-1:0] r_len, n_len, b_len;
    logic [OFFSET_W-1:0]    r_pos, n_pos, b_pos;
    logic [OFFSET_W-1:0]    r_hpos, n_hpos, b_hpos;

    logic                   emit;
    logic [7:0]             emit_byte;
    logic                   emit_valid;
    logic                   emit_last;
    logic [15:0]            plen;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [EXT_W-1:0]       len_ext;

    // A restart beat sees the reset state before it is parsed.
    always_comb begin
        if (i_restart) begin
            b_phase  = PH_HDR0;
            b_first  = '0;
            b_class  = '0;
            b_elem   = '0;
            b_remain = '0;
            b_more   = 1'b0;
            b_long   = 1'b0;
            b_pad    = 1'b0;
            b_len    = '0;
            b_pos    = '0;
            b_hpos   = '0;
        end else begin
            b_phase  = r_phase;
            b_first  = r_first;
            b_class  = r_class;
            b_elem   = r_elem;
            b_remain = r_remain;
            b_more   = r_more;
            b_long   = r_long;
            b_pad    = r_pad;
            b_len    = r_len;
            b_pos    = r_pos;
            b_hpos   = r_hpos;
        end
    end

    // Saturating count of one more parameter byte.
    assign len_inc = (b_len != LEN_MAX) ? b_len + 1'b1 : b_len;

    // Partition length from the word, rounded up to even.
    assign plen = {1'b0, b_first[6:0], i_byte} + {15'd0, i_byte[0]};

    // Phase decoding and next state for the beat on the input.
    always_comb begin
        n_phase    = b_phase;
        n_first    = b_first;
        n_class    = b_class;
        n_elem     = b_elem;
        n_remain   = b_remain;
        n_more     = b_more;
        n_long     = b_long;
        n_pad      = b_pad;
        n_len      = b_len;
        n_pos      = b_pos + 1'b1;
        n_hpos     = b_hpos;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        emit_valid = 1'b0;
        emit_last  = 1'b0;
        case (b_phase)
            PH_HDR1: begin
                n_class = b_first[7:4];
                n_elem  = {b_first[3:0], i_byte[7:5]};
                n_len   = '0;
                n_more  = 1'b0;
                if (i_byte[4:0] == 5'd31) begin
                    n_long  = 1'b1;
                    n_pad   = 1'b0;
                    n_phase = PH_PART0;
                end else begin
                    n_long   = 1'b0;
                    n_remain = {11'd0, i_byte[4:0]};
                    n_pad    = i_byte[0];
                    if (i_byte[4:0] == 5'd0) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end else begin
                        n_phase = PH_SDATA;
                    end
                end
            end
            PH_SDATA: begin
                n_len      = len_inc;
                n_remain   = b_remain - 1'b1;
                emit       = 1'b1;
                emit_byte  = i_byte;
                emit_valid = 1'b1;
                if (n_remain == 16'd0) begin
                    emit_last = 1'b1;
                    n_phase   = b_pad ? PH_SPAD : PH_HDR0;
                    n_pad     = 1'b0;
                end
            end
            PH_SPAD: begin
                n_phase = PH_HDR0;
            end
            PH_PART0: begin
                n_first = i_byte;
                n_phase = PH_PART1;
            end
            PH_PART1: begin
                n_more   = b_first[7];
                n_remain = plen;
                if (plen == 16'd0) begin
                    if (b_first[7]) begin
                        n_phase = PH_PART0;
                    end else begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end
                end else begin
                    n_phase = PH_LDATA;
                end
            end
            PH_LDATA: begin
                n_len      = len_inc;
                n_remain   = b_remain - 1'b1;
                emit       = 1'b1;
                emit_byte  = i_byte;
                emit_valid = 1'b1;
                if (n_remain == 16'd0) begin
                    if (b_more) begin
                        n_phase = PH_PART0;
                    end else begin
                        emit_last = 1'b1;
                        n_phase   = PH_HDR0;
                    end
                end
            end
            default: begin
                n_first = i_byte;
                n_hpos  = b_pos;
                n_phase = PH_HDR1;
            end
        endcase
    end

    // Result item built from the state after this beat.
    assign len_ext = EXT_W'(n_len);
    always_comb begin
        o_result.param_byte   = emit_byte;
        o_result.param_valid  = emit_valid;
        o_result.cmd_last     = emit_last;
        o_result.elem_class   = n_class;
        o_result.element_id   = n_elem;
        o_result.param_length = len_ext[PARAM_LEN_W-1:0];
        o_result.cmd_offset   = n_hpos;
        o_result.long_form    = n_long;
    end
    assign o_push = i_take & emit;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_first  <= '0;
            r_class  <= '0;
            r_elem   <= '0;
            r_remain <= '0;
            r_more   <= 1'b0;
            r_long   <= 1'b0;
            r_pad    <= 1'b0;
            r_len    <= '0;
            r_pos    <= '0;
            r_hpos   <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_class  <= n_class;
            r_elem   <= n_elem;
            r_remain <= n_remain;
            r_more   <= n_more;
            r_long   <= n_long;
            r_pad    <= n_pad;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_hpos   <= n_hpos;
        end
    end

endmodule

// ===== rtl/cbd_queue.sv =====
// Short result queue that decouples the parser from the output stage.
// Depends on cbd_pkg.
`timescale 1ns / 1ps
module cbd_queue
    import cbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_has_room,
    input  logic    i_pop,
    output logic    o_not_empty,
    output t_result o_data
);

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic                  do_pop;

    assign o_has_room  = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_pop      = i_pop & o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QUEUE_CW'(i_push) - QUEUE_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; written only when there is room.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/cbd_back.sv =====
// Back part of the deframer: output register that presents result beats
// to the downstream receiver. Depends on cbd_pkg.
`timescale 1ns / 1ps
module cbd_back
    import cbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  t_result              i_data,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tlast,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    logic    r_valid, n_valid;
    t_result r_out;

    // Load a new item when the register is empty or being emptied.
    assign o_pop   = i_avail & (!r_valid | i_m_tready);
    assign n_valid = o_pop | (r_valid & !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_data;
        end
    end

    // Beat packing.
    assign o_m_tvalid = r_valid;
    assign o_m_tlast  = r_out.cmd_last;
    assign o_m_tuser  = {r_out.long_form, r_out.param_valid};
    assign o_m_tdata  = {5'd0, r_out.cmd_offset, r_out.param_length,
                         r_out.element_id, r_out.elem_class, r_out.param_byte};

endmodule

// ===== tb/cgm_binary_command_deframer_core_test.sv =====
// Self-checking testbench for cgm_binary_command_deframer_core.
// A scoreboard class predicts every output beat from the accepted stream bytes.
// The testbench depends on cbd_pkg and on the top level of the deframer only.
`timescale 1ns / 1ps
module cgm_binary_command_deframer_core_test;
    import cbd_pkg::*;

    localparam int LEN_BITS      = DEF_LENGTH_BITS;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_BYTES   = 450;
    localparam logic [4:0] LONG_FORM_LEN = 5'd31;

    // Predicts the deframer output and checks each output beat against it.
    class deframer_scoreboard;
        typedef enum logic [2:0] {
            PH_HDR_HI, PH_HDR_LO, PH_SHORT, PH_PAD, PH_WORD_HI, PH_WORD_LO, PH_LONG
        } t_parse_phase;

        t_parse_phase        phase;
        logic [7:0]          held_byte;
        logic [3:0]          cls;
        logic [6:0]          elem;
        logic [15:0]         remaining;
        logic                more_parts;
        logic                is_long;
        logic                pad_pending;
        logic [LEN_BITS-1:0] byte_count;
        logic [31:0]         position;
        logic [31:0]         header_pos;
        t_result             expected_q[$];
        int                  errors;
        int                  beats_checked;

        function new();
            errors        = 0;
            beats_checked = 0;
            restart_parser();
        endfunction

        function void restart_parser();
            phase       = PH_HDR_HI;
            held_byte   = '0;
            cls         = '0;
            elem        = '0;
            remaining   = '0;
            more_parts  = 1'b0;
            is_long     = 1'b0;
            pad_pending = 1'b0;
            byte_count  = '0;
            position    = '0;
            header_pos  = '0;
        endfunction

        function void push_result(logic [7:0] data, logic valid, logic last);
            t_result r;
            r.param_byte   = data;
            r.param_valid  = valid;
            r.cmd_last     = last;
            r.elem_class   = cls;
            r.element_id   = elem;
            r.param_length = byte_count[PARAM_LEN_W-1:0];
            r.cmd_offset   = header_pos;
            r.long_form    = is_long;
            expected_q.push_back(r);
        endfunction

        // The length counter sticks at its top value.
        function void count_param();
            if (byte_count != '1) begin
                byte_count = byte_count + 1'b1;
            end
        endfunction

        // Advances the parser by one accepted stream byte.
        function void note_byte(logic [7:0] b, logic restart);
            logic [31:0] here;
            logic [15:0] plen;
            if (restart) begin
                restart_parser();
            end
            here     = position;
            position = position + 1;
            case (phase)
                PH_HDR_LO: begin
                    cls        = held_byte[7:4];
                    elem       = {held_byte[3:0], b[7:5]};
                    byte_count = '0;
                    more_parts = 1'b0;
                    if (b[4:0] == LONG_FORM_LEN) begin
                        is_long     = 1'b1;
                        pad_pending = 1'b0;
                        phase       = PH_WORD_HI;
                    end else begin
                        is_long     = 1'b0;
                        remaining   = {11'd0, b[4:0]};
                        pad_pending = b[0];
                        if (b[4:0] == 5'd0) begin
                            push_result(8'h00, 1'b0, 1'b1);
                            phase = PH_HDR_HI;
                        end else begin
                            phase = PH_SHORT;
                        end
                    end
                end
                PH_SHORT: begin
                    count_param();
                    remaining = remaining - 1'b1;
                    if (remaining == 16'd0) begin
                        push_result(b, 1'b1, 1'b1);
                        phase       = pad_pending ? PH_PAD : PH_HDR_HI;
                        pad_pending = 1'b0;
                    end else begin
                        push_result(b, 1'b1, 1'b0);
                    end
                end
                PH_PAD: begin
                    phase = PH_HDR_HI;
                end
                PH_WORD_HI: begin
                    held_byte = b;
                    phase     = PH_WORD_LO;
                end
                PH_WORD_LO: begin
                    // Odd partition lengths are rounded up to even.
                    plen = {1'b0, held_byte[6:0], b};
                    if (plen[0]) begin
                        plen = plen + 1'b1;
                    end
                    more_parts = held_byte[7];
                    remaining  = plen;
                    if (plen == 16'd0) begin
                        if (more_parts) begin
                            phase = PH_WORD_HI;
                        end else begin
                            push_result(8'h00, 1'b0, 1'b1);
                            phase = PH_HDR_HI;
                        end
                    end else begin
                        phase = PH_LONG;
                    end
                end
                PH_LONG: begin
                    count_param();
                    remaining = remaining - 1'b1;
                    if (remaining == 16'd0) begin
                        push_result(b, 1'b1, !more_parts);
                        phase = more_parts ? PH_WORD_HI : PH_HDR_HI;
                    end else begin
                        push_result(b, 1'b1, 1'b0);
                    end
                end
                default: begin
                    held_byte  = b;
                    header_pos = here;
                    phase      = PH_HDR_LO;
                end
            endcase
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                if (errors < 10) begin
                    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h",
                             $time, name, want, got);
                end
                errors++;
            end
        endfunction

        // Compares one output beat with the oldest prediction.
        function void check_beat(t_result got, logic [4:0] pad_bits);
            t_result want;
            if (expected_q.size() == 0) begin
                if (errors < 10) begin
                    $display("%0t: output beat with nothing expected (byte 0x%0h)",
                             $time, got.param_byte);
                end
                errors++;
            end else begin
                want = expected_q.pop_front();
                beats_checked++;
                check_field("param_byte", want.param_byte, got.param_byte);
                check_field("param_valid", want.param_valid, got.param_valid);
                check_field("cmd_last", want.cmd_last, got.cmd_last);
                check_field("elem_class", want.elem_class, got.elem_class);
                check_field("element_id", want.element_id, got.element_id);
                check_field("param_length", want.param_length, got.param_length);
                check_field("cmd_offset", want.cmd_offset, got.cmd_offset);
                check_field("long_form", want.long_form, got.long_form);
                check_field("tdata padding", 0, pad_bits);
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic [M_TUSER_W-1:0] o_m_tuser;

    deframer_scoreboard sb = new();

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int bytes_sent     = 0;
    int restarts_sent  = 0;
    int short_cmds     = 0;
    int long_cmds      = 0;
    int broken_runs    = 0;
    int quiet_cycles   = 0;
    bit resync         = 1'b0;

    cgm_binary_command_deframer_core #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Monitor: input beats feed the prediction before output beats are checked.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_s_tvalid && o_s_tready) begin
                sb.note_byte(i_s_tdata, i_s_tuser);
                quiet_cycles = 0;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.param_byte   = o_m_tdata[7:0];
                got.elem_class   = o_m_tdata[11:8];
                got.element_id   = o_m_tdata[18:12];
                got.param_length = o_m_tdata[42:19];
                got.cmd_offset   = o_m_tdata[74:43];
                got.cmd_last     = o_m_tlast;
                got.param_valid  = o_m_tuser[0];
                got.long_form    = o_m_tuser[1];
                sb.check_beat(got, o_m_tdata[79:75]);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: stalls at random according to the current idling mode.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Sends one stream byte and waits until it is accepted.
    task automatic send_beat(input logic [7:0] b, input logic rs);
        while ($urandom_range(99) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= rs;
        bytes_sent++;
        if (rs) begin
            restarts_sent++;
        end
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
    endtask

    task automatic send_header(input logic [3:0] c, input logic [6:0] e,
                               input logic [4:0] len5, input logic rs);
        send_beat({c, e[6:3]}, rs);
        send_beat({e[2:0], len5}, 1'b0);
    endtask

    // Short form: up to 30 parameter bytes, then a pad byte if the length is odd.
    task automatic send_short_cmd(input logic rs);
        int len;
        len = $urandom_range(30);
        send_header(4'($urandom_range(15)), 7'($urandom_range(127)), 5'(len), rs);
        repeat (len + len % 2) send_beat(8'($urandom_range(255)), 1'b0);
        short_cmds++;
    endtask

    // Long form: one to three partitions, some empty, mostly short.
    task automatic send_long_cmd(input logic rs);
        int          parts;
        int          pick;
        int          plen;
        logic [15:0] word;
        parts = $urandom_range(1, 3);
        send_header(4'($urandom_range(15)), 7'($urandom_range(127)), LONG_FORM_LEN, rs);
        for (int p = 0; p < parts; p++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                plen = 0;
            end else if (pick < 90) begin
                plen = $urandom_range(1, 16);
            end else begin
                plen = $urandom_range(17, 200);
            end
            word = {p != parts - 1, plen[14:0]};
            send_beat(word[15:8], 1'b0);
            send_beat(word[7:0], 1'b0);
            repeat (plen + plen % 2) send_beat(8'($urandom_range(255)), 1'b0);
        end
        long_cmds++;
    endtask

    // A command cut short; the next command restarts the parser.
    task automatic send_broken_cmd(input logic rs);
        int len;
        len = $urandom_range(4, 30);
        if ($urandom_range(1)) begin
            send_header(4'($urandom_range(15)), 7'($urandom_range(127)), 5'(len), rs);
            repeat ($urandom_range(len - 1)) send_beat(8'($urandom_range(255)), 1'b0);
        end else begin
            send_header(4'($urandom_range(15)), 7'($urandom_range(127)), LONG_FORM_LEN, rs);
            send_beat(8'h00, 1'b0);
            send_beat(8'(len), 1'b0);
            repeat ($urandom_range(len - 1)) send_beat(8'($urandom_range(255)), 1'b0);
        end
        broken_runs++;
    endtask

    // Mostly well-formed commands, with some broken ones and raw noise.
    task automatic run_random_phase(input int gap_pct, input int stall_pct);
        int   stop_at;
        int   pick;
        logic rs;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at        = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at) begin
            pick   = $urandom_range(99);
            rs     = resync || ($urandom_range(99) < 4);
            resync = 1'b0;
            if (pick < 45) begin
                send_short_cmd(rs);
            end else if (pick < 82) begin
                send_long_cmd(rs);
            end else if (pick < 91) begin
                send_broken_cmd(rs);
                resync = 1'b1;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                broken_runs++;
                resync = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty short-form command with an all-zero header.
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        // Top class and element, odd length one followed by its pad byte.
        send_beat(8'hFF, 1'b0);
        send_beat(8'hE1, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h5A, 1'b0);
        // Even length two, so no pad.
        send_beat(8'h12, 1'b0);
        send_beat(8'h42, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hA5, 1'b0);
        // Long form closed by an empty final partition.
        send_beat(8'h4A, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        // Long form: empty partition with more to come, then length one rounded to two.
        send_beat(8'h21, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h3C, 1'b0);
        send_beat(8'hC3, 1'b0);
        // Restart in the middle of a short command, straight into an empty one.
        send_beat(8'h33, 1'b0);
        send_beat(8'h45, 1'b0);
        send_beat(8'h77, 1'b0);
        send_beat(8'h10, 1'b1);
        send_beat(8'h40, 1'b0);

        // Largest partition word (0x7FFF, rounded to 0x8000), cut short by a restart.
        send_header(4'h9, 7'h55, LONG_FORM_LEN, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        repeat (24) send_beat(8'($urandom_range(255)), 1'b0);
        broken_runs++;
        resync = 1'b1;

        // Random traffic under each idling mode.
        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(12, 12);

        i_s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d stream bytes: %0d short and %0d long commands,",
                 bytes_sent, short_cmds, long_cmds);
        $display("%0d broken runs and %0d restarts; checked %0d output beats, %0d mismatches.",
                 broken_runs, restarts_sent, sb.beats_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
